### hw/rtl/wtmu_pkg.sv
// Shared types and constants for the monotonic microsecond timer.
// Used by the front end, the command queue, the back end and the top level.
`timescale 1ns / 1ps

package wtmu_pkg;

  localparam int unsigned CMD_DEPTH  = 2;
  localparam int unsigned CMD_PTR_W  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // rounded quotient works on counts * 1e6 + clock_hz / 2, 84 bits wide
  localparam int unsigned DVD_W      = 84;
  localparam int unsigned DIV_STEPS  = DVD_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [19:0] US_PER_S = 20'd1000000;

  localparam logic [31:0] SPAN_RST   = 32'd100001;
  localparam logic [31:0] CLK_HZ_RST = 32'd100000000;
  localparam logic [19:0] UPT_RST    = 20'd1000;
  localparam logic [15:0] STALL_RST  = 16'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CNT_SPAN     = 3'd0,
    CFG_COUNT_UP     = 3'd1,
    CFG_CLOCK_HZ     = 3'd2,
    CFG_US_PER_TICK  = 3'd3,
    CFG_STALL_LIMIT  = 3'd4,
    CFG_TIMER_READY  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] cnt_span;
    logic        count_up;
    logic [31:0] clock_hz;
    logic [19:0] us_per_tick;
    logic [15:0] stall_limit;
    logic        timer_ready;
  } cfg_t;

  // value holds the total count for a timer item, the tick count for a fallback
  typedef struct packed {
    logic        fallback;
    logic        wrap;
    logic        stall;
    logic [63:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FB,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_DIV,
    BK_DONE
  } back_state_e;

endpackage

### hw/rtl/wrapping_timer_to_monotonic_us.sv
// Top level of the monotonic microsecond timer: configuration registers,
// front end, command queue and back end. Depends on wtmu_pkg and all wtmu_* modules.
`timescale 1ns / 1ps

// Each request yields exactly one result, in order. A request that falls back
// to the tick count uses one multiply and skips the divider; a request served
// by the hardware counter spends most of its time in the radix-2 divider of
// the back end, which retires one quotient bit per cycle over the 84-bit
// scaled count. The front end takes the next request and updates the counter
// state while the back end is still dividing, with up to two commands queued
// between them; a finished result waits in the output register until popped
// while the back end moves on to the next one. There is no clearing pass after
// reset. Registers are written by index through the cfg_* port and should only
// be changed while no request is in flight.

module wrapping_timer_to_monotonic_us
  import wtmu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  logic [31:0]           raw_count_i,
  input  logic                  status_ok_i,
  input  logic [31:0]           tick_count_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [63:0]           time_us_o,
  output logic                  used_fallback_o,
  output logic                  wrapped_o,
  output logic                  stalled_o,
  output logic                  clamped_o
);

  cfg_t cfg_q;
  cmd_t cmd_wr;
  cmd_t cmd_rd;
  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;
  logic res_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cnt_span     <= SPAN_RST;
      cfg_q.count_up     <= 1'b1;
      cfg_q.clock_hz     <= CLK_HZ_RST;
      cfg_q.us_per_tick  <= UPT_RST;
      cfg_q.stall_limit  <= STALL_RST;
      cfg_q.timer_ready  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CNT_SPAN:     cfg_q.cnt_span     <= cfg_data_i;
        CFG_COUNT_UP:     cfg_q.count_up     <= cfg_data_i[0];
        CFG_CLOCK_HZ:     cfg_q.clock_hz     <= cfg_data_i;
        CFG_US_PER_TICK:  cfg_q.us_per_tick  <= cfg_data_i[19:0];
        CFG_STALL_LIMIT:  cfg_q.stall_limit  <= cfg_data_i[15:0];
        CFG_TIMER_READY:  cfg_q.timer_ready  <= cfg_data_i[0];
        default: begin
          // drop writes beyond the register list
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  wtmu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push_i       (push),
    .raw_count_i  (raw_count_i),
    .status_ok_i  (status_ok_i),
    .tick_count_i (tick_count_i),
    .full_o       (full),
    .cmd_valid_o  (cmd_push),
    .cmd_o        (cmd_wr),
    .cmd_full_i   (cmd_full)
  );

  wtmu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_wr),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_rd),
    .empty_o (cmd_empty)
  );

  wtmu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd_rd),
    .cmd_empty_i     (cmd_empty),
    .cmd_pop_o       (cmd_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .res_wr_o        (res_wr),
    .time_us_o       (time_us_o),
    .used_fallback_o (used_fallback_o),
    .wrapped_o       (wrapped_o),
    .stalled_o       (stalled_o),
    .clamped_o       (clamped_o)
  );

  a_cmd_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_push && cmd_full) || full)
    else $error("command offered to a full queue without stalling the input");

  a_cmd_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_pop && cmd_empty))
    else $error("back end took a command from an empty queue");

  a_stall_falls_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && stalled_o) |-> used_fallback_o)
    else $error("stalled result not taken from tick fallback");

  a_pop_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !res_wr) |=> empty)
    else $error("popped result beat still shown");

endmodule

### hw/rtl/wtmu_front.sv
// Front end: takes timestamp requests, tracks counter position, total count
// and stall state, and issues one command per request. Depends on wtmu_pkg.
`timescale 1ns / 1ps

module wtmu_front
  import wtmu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        push_i,
  input  logic [31:0] raw_count_i,
  input  logic        status_ok_i,
  input  logic [31:0] tick_count_i,
  output logic        full_o,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_full_i
);

  logic        hold_valid_q, hold_valid_d;
  logic [31:0] pos_q;
  logic        ok_q;
  logic [31:0] ticks_q;
  logic [31:0] last_pos_q;
  logic [63:0] total_q;
  logic [31:0] zero_run_q;
  logic        stall_flag_q;

  logic        accept;
  logic        drain;
  logic        active;
  logic        span_zero;
  logic        backward;
  logic [31:0] delta;
  logic [31:0] zr_inc;
  logic        stall_now;
  logic [63:0] total_sum;

  assign drain       = hold_valid_q && !cmd_full_i;
  assign full_o      = hold_valid_q && cmd_full_i;
  assign accept      = push_i && !full_o;
  assign cmd_valid_o = hold_valid_q;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (drain) begin
      hold_valid_d = 1'b0;
    end
    if (accept) begin
      hold_valid_d = 1'b1;
    end
  end

  assign active    = cfg_i.timer_ready && (cfg_i.clock_hz != 32'd0) && ok_q;
  assign span_zero = (cfg_i.cnt_span == 32'd0);
  assign backward  = (pos_q < last_pos_q);
  assign delta     = backward ? (cfg_i.cnt_span - last_pos_q + pos_q)
                              : (pos_q - last_pos_q);
  assign zr_inc    = (&zero_run_q) ? zero_run_q : (zero_run_q + 32'd1);
  assign stall_now = (delta == 32'd0)
                   ? (stall_flag_q || (zr_inc >= {16'd0, cfg_i.stall_limit}))
                   : 1'b0;
  assign total_sum = total_q + {32'd0, delta};

  always_comb begin
    cmd_o.fallback = 1'b1;
    cmd_o.wrap     = 1'b0;
    cmd_o.stall    = 1'b0;
    cmd_o.value    = {32'd0, ticks_q};
    if (active && !span_zero) begin
      cmd_o.wrap  = backward;
      cmd_o.stall = stall_now;
      if (!stall_now) begin
        cmd_o.fallback = 1'b0;
        cmd_o.value    = total_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      last_pos_q   <= 32'd0;
      total_q      <= 64'd0;
      zero_run_q   <= 32'd0;
      stall_flag_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      if (drain && active) begin
        last_pos_q <= pos_q;
        if (!span_zero) begin
          total_q      <= total_sum;
          zero_run_q   <= (delta == 32'd0) ? zr_inc : 32'd0;
          stall_flag_q <= stall_now;
        end
      end
    end
  end

  // fold count direction into the position as the beat is taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q   <= cfg_i.count_up ? raw_count_i
                                : (cfg_i.cnt_span - 32'd1 - raw_count_i);
      ok_q    <= status_ok_i;
      ticks_q <= tick_count_i;
    end
  end

endmodule

### hw/rtl/wtmu_fifo.sv
// Short command queue between the front end and the back end.
// Depends on wtmu_pkg for the command type and depth.
`timescale 1ns / 1ps

module wtmu_fifo
  import wtmu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q;
  logic [CMD_PTR_W-1:0] rd_ptr_q;
  logic [CMD_PTR_W:0]   count_q;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (count_q == (CMD_PTR_W + 1)'(CMD_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/wtmu_back.sv
// Back end: turns commands into timestamps (tick product or rounded
// radix-2 division), applies the monotonic clamp and holds the result beat.
// Depends on wtmu_pkg.
`timescale 1ns / 1ps

module wtmu_back
  import wtmu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  cmd_t        cmd_i,
  input  logic        cmd_empty_i,
  output logic        cmd_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic        res_wr_o,
  output logic [63:0] time_us_o,
  output logic        used_fallback_o,
  output logic        wrapped_o,
  output logic        stalled_o,
  output logic        clamped_o
);

  back_state_e          state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 out_valid_q;
  logic [63:0]          last_out_q;

  logic                 fb_q, wrap_q, stall_q;
  logic [63:0]          val_q;
  logic [DVD_W-1:0]     dvd_q;
  logic [31:0]          rem_q;
  logic [63:0]          quo_q;
  logic [63:0]          out_time_q;
  logic                 out_fb_q, out_wrap_q, out_stall_q, out_clamp_q;

  logic [31:0]          mul_a;
  logic [19:0]          mul_b;
  logic [51:0]          mul_p;
  logic [32:0]          rem_sh;
  logic                 ge;
  logic                 clamp;
  logic [63:0]          cand;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i) begin
          state_d = cmd_i.fallback ? BK_FB : BK_MUL_LO;
        end
      end
      BK_FB:     state_d = BK_DONE;
      BK_MUL_LO: state_d = BK_MUL_HI;
      BK_MUL_HI: state_d = BK_DIV;
      BK_DIV: begin
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_q || pop_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop_o = 1'b0;
    res_wr_o  = 1'b0;
    case (state_q)
      BK_IDLE: cmd_pop_o = !cmd_empty_i;
      BK_DONE: res_wr_o  = !out_valid_q || pop_i;
      default: begin
        cmd_pop_o = 1'b0;
        res_wr_o  = 1'b0;
      end
    endcase
  end

  // one shared 32x20 multiplier for both halves of the count and the ticks
  assign mul_a = (state_q == BK_MUL_HI) ? val_q[63:32] : val_q[31:0];
  assign mul_b = (state_q == BK_FB) ? cfg_i.us_per_tick : US_PER_S;
  assign mul_p = {20'd0, mul_a} * {32'd0, mul_b};

  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, cfg_i.clock_hz});

  assign clamp = (quo_q <= last_out_q);
  assign cand  = clamp ? (last_out_q + 64'd1) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      last_out_q  <= 64'd0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_MUL_HI) begin
        cnt_q <= '0;
      end else if (state_q == BK_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (res_wr_o) begin
        out_valid_q <= 1'b1;
        last_out_q  <= cand;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (cmd_pop_o) begin
          val_q   <= cmd_i.value;
          fb_q    <= cmd_i.fallback;
          wrap_q  <= cmd_i.wrap;
          stall_q <= cmd_i.stall;
        end
      end
      BK_FB: quo_q <= {12'd0, mul_p};
      BK_MUL_LO: begin
        // add half the divisor up front so the quotient rounds to nearest
        dvd_q <= {32'd0, mul_p} + {53'd0, cfg_i.clock_hz[31:1]};
      end
      BK_MUL_HI: begin
        dvd_q <= dvd_q + {mul_p, 32'd0};
        rem_q <= 32'd0;
      end
      BK_DIV: begin
        rem_q <= ge ? 32'(rem_sh - {1'b0, cfg_i.clock_hz}) : rem_sh[31:0];
        dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
        quo_q <= {quo_q[62:0], ge};
      end
      BK_DONE: begin
        if (res_wr_o) begin
          out_time_q  <= cand;
          out_fb_q    <= fb_q;
          out_wrap_q  <= wrap_q;
          out_stall_q <= stall_q;
          out_clamp_q <= clamp;
        end
      end
      default: begin
        quo_q <= quo_q;
      end
    endcase
  end

  assign empty_o         = !out_valid_q;
  assign time_us_o       = out_time_q;
  assign used_fallback_o = out_fb_q;
  assign wrapped_o       = out_wrap_q;
  assign stalled_o       = out_stall_q;
  assign clamped_o       = out_clamp_q;

endmodule

### sim/wrapping_timer_to_monotonic_us_tb.sv
// Self-checking testbench for wrapping_timer_to_monotonic_us: directed table,
// then randomized phases under varying idle/stall pressure. Depends on wtmu_pkg.
`timescale 1ns / 1ps

module wrapping_timer_to_monotonic_us_tb;
  import wtmu_pkg::*;

  localparam int unsigned NUM_PHASES = 10;
  localparam int unsigned PHASE_REQS = 66;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [63:0] time_us;
    logic        used_fallback;
    logic        wrapped;
    logic        stalled;
    logic        clamped;
  } stamp_t;

  typedef enum logic {ROW_WRITE, ROW_REQ} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    cfg_idx_e    idx;
    logic [31:0] data;
    logic [31:0] raw;
    logic        ok;
    logic [31:0] ticks;
    logic        known;
    stamp_t      want;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic [31:0]           raw_count_i = '0;
  logic                  status_ok_i = 1'b0;
  logic [31:0]           tick_count_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [63:0]           time_us_o;
  logic                  used_fallback_o;
  logic                  wrapped_o;
  logic                  stalled_o;
  logic                  clamped_o;

  // shadow of the block: configuration and tracking state
  cfg_t        shadow_cfg;
  logic [31:0] trk_pos;
  logic [63:0] trk_total;
  logic [31:0] trk_zero_run;
  logic        trk_stalled;
  logic [63:0] trk_last_us;

  stamp_t pending_stamps[$];
  row_t   dir_rows[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned fail_count = 0;
  int unsigned n_reqs = 0;
  int unsigned n_results = 0;
  int unsigned n_fallback = 0;
  int unsigned n_wrapped = 0;
  int unsigned n_stalled = 0;
  int unsigned n_clamped = 0;

  wrapping_timer_to_monotonic_us u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .raw_count_i    (raw_count_i),
    .status_ok_i    (status_ok_i),
    .tick_count_i   (tick_count_i),
    .empty          (empty),
    .pop            (pop),
    .time_us_o      (time_us_o),
    .used_fallback_o(used_fallback_o),
    .wrapped_o      (wrapped_o),
    .stalled_o      (stalled_o),
    .clamped_o      (clamped_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #15_000_000;
    $display("%0t: timed out with %0d results outstanding", $time, pending_stamps.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    shadow_cfg.cnt_span     = SPAN_RST;
    shadow_cfg.count_up     = 1'b1;
    shadow_cfg.clock_hz     = CLK_HZ_RST;
    shadow_cfg.us_per_tick  = UPT_RST;
    shadow_cfg.stall_limit  = STALL_RST;
    shadow_cfg.timer_ready  = 1'b0;
    trk_pos      = '0;
    trk_total    = '0;
    trk_zero_run = '0;
    trk_stalled  = 1'b0;
    trk_last_us  = '0;
  end

  // rounded microseconds from a count at hz
  function automatic logic [63:0] us_from_counts(logic [63:0] counts, logic [31:0] hz);
    logic [63:0] h, whole, rest, frac;
    h     = {32'd0, hz};
    whole = counts / h;
    rest  = counts % h;
    frac  = (rest * 64'd1000000 + (h >> 1)) / h;
    return whole * 64'd1000000 + frac;
  endfunction

  function automatic stamp_t predict_stamp(logic [31:0] raw, logic ok, logic [31:0] ticks);
    stamp_t      s;
    logic [31:0] pos, delta;
    logic [63:0] cand;
    s = '0;
    s.used_fallback = 1'b1;
    cand = '0;
    if (shadow_cfg.timer_ready && shadow_cfg.clock_hz != 0 && ok) begin
      pos = shadow_cfg.count_up ? raw : shadow_cfg.cnt_span - 32'd1 - raw;
      if (shadow_cfg.cnt_span == 0) begin
        trk_pos = pos;
      end else begin
        if (pos >= trk_pos) begin
          delta = pos - trk_pos;
        end else begin
          delta = shadow_cfg.cnt_span - trk_pos + pos;
          s.wrapped = 1'b1;
        end
        trk_pos = pos;
        trk_total = trk_total + {32'd0, delta};
        if (delta == 0) begin
          if (trk_zero_run != 32'hFFFF_FFFF) trk_zero_run = trk_zero_run + 32'd1;
          if (trk_zero_run >= {16'd0, shadow_cfg.stall_limit}) trk_stalled = 1'b1;
        end else begin
          trk_zero_run = '0;
          trk_stalled = 1'b0;
        end
        s.stalled = trk_stalled;
        if (!trk_stalled) begin
          cand = us_from_counts(trk_total, shadow_cfg.clock_hz);
          s.used_fallback = 1'b0;
        end
      end
    end
    if (s.used_fallback) cand = {32'd0, ticks} * {44'd0, shadow_cfg.us_per_tick};
    // force strictly increasing output
    if (cand <= trk_last_us) begin
      cand = trk_last_us + 64'd1;
      s.clamped = 1'b1;
    end
    trk_last_us = cand;
    s.time_us = cand;
    return s;
  endfunction

  function automatic void row_w(cfg_idx_e idx, logic [31:0] data);
    row_t r;
    r = '{kind: ROW_WRITE, idx: idx, data: data, raw: '0, ok: 1'b0, ticks: '0,
          known: 1'b0, want: '0};
    dir_rows.push_back(r);
  endfunction

  function automatic void row_i(logic [31:0] raw, logic ok, logic [31:0] ticks,
                                logic known, stamp_t want);
    row_t r;
    r = '{kind: ROW_REQ, idx: CFG_CNT_SPAN, data: '0, raw: raw, ok: ok, ticks: ticks,
          known: known, want: want};
    dir_rows.push_back(r);
  endfunction

  // called just after a falling edge; returns just after a falling edge
  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_CNT_SPAN:     shadow_cfg.cnt_span = data;
      CFG_COUNT_UP:     shadow_cfg.count_up = data[0];
      CFG_CLOCK_HZ:     shadow_cfg.clock_hz = data;
      CFG_US_PER_TICK:  shadow_cfg.us_per_tick = data[19:0];
      CFG_STALL_LIMIT:  shadow_cfg.stall_limit = data[15:0];
      CFG_TIMER_READY:  shadow_cfg.timer_ready = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic offer(logic [31:0] raw, logic ok, logic [31:0] ticks,
                       logic known, stamp_t want);
    stamp_t s;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push         <= 1'b1;
    raw_count_i  <= raw;
    status_ok_i  <= ok;
    tick_count_i <= ticks;
    do @(posedge clk_i); while (full);
    s = predict_stamp(raw, ok, ticks);
    pending_stamps.push_back(known ? want : s);
    n_reqs++;
    @(negedge clk_i);
  endtask

  // hold the sender until every result is back
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk_i); while (pending_stamps.size() != 0);
  endtask

  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    stamp_t got, want;
    if (rst_ni && pop && !empty) begin
      got = {time_us_o, used_fallback_o, wrapped_o, stalled_o, clamped_o};
      n_results++;
      if (pending_stamps.size() == 0) begin
        $display("%0t: unexpected beat: time_us=%0d fb=%b wrap=%b stall=%b clamp=%b",
                 $time, got.time_us, got.used_fallback, got.wrapped, got.stalled,
                 got.clamped);
        fail_count++;
      end else begin
        want = pending_stamps.pop_front();
        if (got !== want) begin
          $display("%0t: expected time_us=%0d fb=%b wrap=%b stall=%b clamp=%b", $time,
                   want.time_us, want.used_fallback, want.wrapped, want.stalled,
                   want.clamped);
          $display("%0t:   actual time_us=%0d fb=%b wrap=%b stall=%b clamp=%b", $time,
                   got.time_us, got.used_fallback, got.wrapped, got.stalled, got.clamped);
          fail_count++;
        end
      end
      if (got.used_fallback === 1'b1) n_fallback++;
      if (got.wrapped === 1'b1) n_wrapped++;
      if (got.stalled === 1'b1) n_stalled++;
      if (got.clamped === 1'b1) n_clamped++;
    end
  end

  initial begin : stimulus
    logic [31:0] span, hz, raw, ticks, junk, upt;
    logic [63:0] step, p64, span64, t64;
    logic [95:0] ratio;
    logic        ok, up;
    int unsigned rr, zero_left;

    zero_left = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // after reset the timer is not ready: tick fallback only
    row_i(32'd0, 1'b1, 32'd0, 1'b1, {64'd1, 1'b1, 1'b0, 1'b0, 1'b1});
    row_i(32'hFFFF_FFFF, 1'b1, 32'd1, 1'b1, {64'd1000, 1'b1, 1'b0, 1'b0, 1'b0});
    row_i(32'd5, 1'b0, 32'd0, 1'b1, {64'd1001, 1'b1, 1'b0, 1'b0, 1'b1});
    row_w(CFG_TIMER_READY, 32'd1);
    row_w(CFG_CNT_SPAN, 32'hFFFF_FFFF);
    row_w(CFG_CLOCK_HZ, 32'hFFFF_FFFF);
    row_i(32'd0, 1'b1, 32'd0, 1'b1, {64'd1002, 1'b0, 1'b0, 1'b0, 1'b1});
    row_i(32'hFFFF_FFFE, 1'b1, 32'd0, 1'b0, '0);
    row_i(32'd3, 1'b1, 32'd0, 1'b0, '0);             // wrap
    row_i(32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0, '0);     // sample outside the span
    row_w(CFG_COUNT_UP, 32'd0);
    row_i(32'd0, 1'b1, 32'd0, 1'b0, '0);
    row_i(32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0, '0);
    row_w(CFG_STALL_LIMIT, 32'd2);
    row_i(32'd0, 1'b1, 32'd0, 1'b0, '0);
    row_i(32'd0, 1'b1, 32'd0, 1'b0, '0);
    row_i(32'd0, 1'b1, 32'd3, 1'b0, '0);             // zero run reaches the limit
    row_i(32'd0, 1'b0, 32'd4, 1'b0, '0);             // failed read while stalled
    row_i(32'd100, 1'b1, 32'd0, 1'b0, '0);           // nonzero delta clears the stall
    row_w(CFG_STALL_LIMIT, 32'd0);
    row_i(32'd100, 1'b1, 32'd0, 1'b0, '0);           // limit zero stalls at once
    row_w(CFG_STALL_LIMIT, 32'h0000_FFFF);
    row_w(CFG_CLOCK_HZ, 32'd0);
    row_i(32'd7, 1'b1, 32'd2000, 1'b0, '0);          // zero clock falls back
    row_w(CFG_CLOCK_HZ, 32'd100000000);
    row_w(CFG_CNT_SPAN, 32'd0);
    row_i(32'd9, 1'b1, 32'd0, 1'b0, '0);             // zero span only moves the position
    row_w(CFG_CNT_SPAN, 32'd1);
    row_i(32'd0, 1'b1, 32'd0, 1'b0, '0);
    row_w(CFG_US_PER_TICK, 32'd1);
    row_i(32'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, '0);
    row_w(CFG_US_PER_TICK, 32'd1000000);
    row_i(32'd0, 1'b0, 32'd5000, 1'b0, '0);
    row_w(CFG_TIMER_READY, 32'd0);
    row_i(32'd1, 1'b1, 32'd0, 1'b0, '0);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_WRITE) begin
        drain();
        write_reg(dir_rows[k].idx, dir_rows[k].data);
      end else begin
        offer(dir_rows[k].raw, dir_rows[k].ok, dir_rows[k].ticks, dir_rows[k].known,
              dir_rows[k].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case ($urandom_range(0, 3))
        0: span = $urandom_range(2, 64);
        1: span = $urandom_range(65, 1000000);
        2: span = $urandom;
        default: span = 32'hFFFF_FFFF;
      endcase
      // steer the clock so counter time lands near the last output
      if (trk_last_us == 0 || $urandom_range(0, 3) == 0) begin
        hz = $urandom;
      end else begin
        ratio = ({32'd0, trk_total} * 96'd1000000) / {32'd0, trk_last_us};
        if (ratio == 0) hz = 32'd1;
        else if (ratio > 96'hFFFF_FFFF) hz = 32'hFFFF_FFFF;
        else hz = ratio[31:0];
      end
      if (ph == NUM_PHASES - 1) begin
        span = $urandom_range(2, 16);
        hz = 32'd1;
      end
      up = $urandom_range(0, 1);
      upt = $urandom_range(1, 1000000);
      junk = $urandom;
      write_reg(CFG_CNT_SPAN, span);
      write_reg(CFG_CLOCK_HZ, hz);
      write_reg(CFG_COUNT_UP, {junk[31:1], up});
      write_reg(CFG_US_PER_TICK, {junk[31:20], upt[19:0]});
      write_reg(CFG_STALL_LIMIT, {junk[31:16],
                ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                            : 16'($urandom_range(1, 4))});
      write_reg(CFG_TIMER_READY, {junk[31:1], ($urandom_range(0, 9) != 0) ||
                                              (ph == NUM_PHASES - 1)});
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      // back up the result side while requests keep coming
      if (ph == 0) hold_req = HOLD_CYCLES;
      span64 = {32'd0, shadow_cfg.cnt_span};
      for (int n = 0; n < PHASE_REQS; n++) begin
        rr = $urandom_range(0, 99);
        ok = (rr >= 5);
        if (rr >= 5 && rr < 8 || span64 == 0) begin
          raw = $urandom;
        end else begin
          if (zero_left != 0) begin
            zero_left--;
            step = 0;
          end else if ($urandom_range(0, 99) < 10) begin
            zero_left = $urandom_range(0, 5);
            step = 0;
          end else if ($urandom_range(0, 99) < 65) begin
            step = $urandom_range(1, shadow_cfg.cnt_span / 16 + 1);
          end else begin
            step = $urandom_range(1, shadow_cfg.cnt_span);
          end
          p64 = ({32'd0, trk_pos} % span64 + step) % span64;
          raw = shadow_cfg.count_up ? p64[31:0]
                                    : shadow_cfg.cnt_span - 32'd1 - p64[31:0];
        end
        if ($urandom_range(0, 99) < 5) begin
          ticks = $urandom;
        end else begin
          t64 = trk_last_us / {44'd0, shadow_cfg.us_per_tick};
          ticks = (t64 > 64'hFFFF_FFFD) ? 32'hFFFF_FFFF
                                        : t64[31:0] + 32'($urandom_range(0, 2));
        end
        offer(raw, ok, ticks, 1'b0, '0);
      end
    end

    drain();
    repeat (200) @(negedge clk_i);
    if (pending_stamps.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_stamps.size());
      fail_count++;
    end
    $display("Sent %0d requests over %0d random phases; %0d results checked.",
             n_reqs, NUM_PHASES, n_results);
    $display("Results seen: %0d fallback, %0d wrapped, %0d stalled, %0d clamped.",
             n_fallback, n_wrapped, n_stalled, n_clamped);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
